[src/prq_pkg.sv]
// ----------------------------------------------------------------------------
// prq_pkg
// Types and codes shared by the sorted request queue modules.
// ----------------------------------------------------------------------------
package prq_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_SERVE  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_NONE    = 2'd2,
    STATUS_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] pid;
    logic [7:0] prio;
    logic       rep;
    logic [7:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_INS,
    ST_HEAD,
    ST_RESP
  } state_e;

  localparam int unsigned OccW = 6;

endpackage

[src/prq_req_if.sv]
// ----------------------------------------------------------------------------
// prq_req_if
// Request channel of the sorted request queue: valid/ready and one item.
// ----------------------------------------------------------------------------
interface prq_req_if;

  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] req_pid;
  logic [7:0] req_priority;
  logic       req_repeat;
  logic [7:0] req_tag;

  modport source (
    output valid, req_type, req_pid, req_priority, req_repeat, req_tag,
    input  ready
  );

  modport sink (
    input  valid, req_type, req_pid, req_priority, req_repeat, req_tag,
    output ready
  );

endinterface

[src/prq_rsp_if.sv]
// ----------------------------------------------------------------------------
// prq_rsp_if
// Response channel of the sorted request queue: valid/ready and one item.
// ----------------------------------------------------------------------------
interface prq_rsp_if;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_pid;
  logic [7:0] out_priority;
  logic       out_repeat;
  logic [7:0] out_tag;
  logic [5:0] occupancy;

  modport source (
    output valid, status, out_pid, out_priority, out_repeat, out_tag, occupancy,
    input  ready
  );

  modport sink (
    input  valid, status, out_pid, out_priority, out_repeat, out_tag, occupancy,
    output ready
  );

endinterface

[src/prq_mem.sv]
// ----------------------------------------------------------------------------
// prq_mem
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prq_mem #(
  parameter int unsigned QUEUE_DEPTH = 32,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  prq_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output prq_pkg::entry_t  rdata_o
);
  import prq_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/prq_ctrl.sv]
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer that walks the entry storage one entry per cycle, with a single
// compare unit, to insert, cancel and serve entries of the sorted queue.
// ----------------------------------------------------------------------------
module prq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 32,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  prq_req_if.sink          req_i,
  prq_rsp_if.source        rsp_o,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output prq_pkg::entry_t  mem_wdata_o,
  output logic [AW-1:0]    mem_raddr_o,
  input  prq_pkg::entry_t  mem_rdata_i
);
  import prq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            found_q, found_d;
  status_e         status_q, status_d;
  logic [AW-1:0]   idx_q, idx_d;
  entry_t          entry_q, entry_d;
  logic [7:0]      key_q, key_d;
  logic            serve_q, serve_d;

  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   idx_p1;
  logic [AW-1:0]   idx_m1;
  logic            last;
  logic            hit;
  entry_t          entry_sel;
  logic [CW+OccW-1:0] occ_ext;

  assign cnt_m1    = count_q - 1'b1;
  assign idx_p1    = idx_q + 1'b1;
  assign idx_m1    = idx_q - 1'b1;
  assign last      = (CW'(idx_q) == cnt_m1);
  assign hit       = !found_q && (serve_q ? (idx_q == '0) : (mem_rdata_i.pid == key_q));
  assign entry_sel = hit ? mem_rdata_i : entry_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    found_d     = found_q;
    status_d    = status_q;
    idx_d       = idx_q;
    entry_d     = entry_q;
    key_d       = key_q;
    serve_d     = serve_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_p1;
    mem_wdata_o = entry_q;
    mem_raddr_o = idx_p1;
    req_i.ready = 1'b0;
    rsp_o.valid = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        mem_raddr_o = '0;
        if (req_i.valid) begin
          found_d  = 1'b0;
          status_d = STATUS_OK;
          idx_d    = '0;
          key_d    = req_i.req_pid;
          case (req_type_e'(req_i.req_type))
            REQ_INSERT: begin
              serve_d = 1'b0;
              if (req_i.req_priority == 8'd0) begin
                status_d = STATUS_INVALID;
                state_d  = ST_RESP;
              end else if (count_q == DepthC) begin
                status_d = STATUS_FULL;
                state_d  = ST_RESP;
              end else begin
                entry_d = '{pid: req_i.req_pid, prio: req_i.req_priority,
                            rep: req_i.req_repeat, tag: req_i.req_tag};
                state_d = ST_PREP;
              end
            end
            REQ_CANCEL, REQ_SERVE: begin
              serve_d = (req_type_e'(req_i.req_type) == REQ_SERVE);
              if (count_q == '0) begin
                status_d = STATUS_NONE;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              serve_d  = 1'b0;
              status_d = STATUS_INVALID;
              state_d  = ST_RESP;
            end
          endcase
        end
      end

      // Start an insert walk from the tail, or place directly into an empty queue.
      ST_PREP: begin
        if (count_q == '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = '0;
          count_d     = count_q + 1'b1;
          state_d     = ST_RESP;
        end else begin
          mem_raddr_o = cnt_m1[AW-1:0];
          idx_d       = cnt_m1[AW-1:0];
          state_d     = ST_INS;
        end
      end

      // Forward walk: find the entry to remove, then move every later entry
      // down by one place.
      ST_SCAN: begin
        mem_raddr_o = idx_p1;
        idx_d       = idx_p1;
        if (hit) begin
          found_d = 1'b1;
          entry_d = mem_rdata_i;
        end else if (found_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_m1;
          mem_wdata_o = mem_rdata_i;
        end
        if (last) begin
          if (found_q || hit) begin
            count_d = cnt_m1;
            state_d = (serve_q && entry_sel.rep) ? ST_PREP : ST_RESP;
          end else begin
            status_d = STATUS_NONE;
            state_d  = ST_RESP;
          end
        end
      end

      // Backward walk: shift lower-priority entries up until the new entry fits.
      ST_INS: begin
        mem_raddr_o = idx_m1;
        idx_d       = idx_m1;
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_p1;
        if (mem_rdata_i.prio >= entry_q.prio) begin
          mem_wdata_o = entry_q;
          count_d     = count_q + 1'b1;
          state_d     = ST_RESP;
        end else begin
          mem_wdata_o = mem_rdata_i;
          if (idx_q == '0) begin
            state_d = ST_HEAD;
          end
        end
      end

      ST_HEAD: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        count_d     = count_q + 1'b1;
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        rsp_o.valid = 1'b1;
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      found_q  <= 1'b0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    entry_q <= entry_d;
    key_q   <= key_d;
    serve_q <= serve_d;
  end

  assign occ_ext            = {{OccW{1'b0}}, count_q};
  assign rsp_o.status       = status_q;
  assign rsp_o.out_pid      = found_q ? entry_q.pid  : 8'd0;
  assign rsp_o.out_priority = found_q ? entry_q.prio : 8'd0;
  assign rsp_o.out_repeat   = found_q ? entry_q.rep  : 1'b0;
  assign rsp_o.out_tag      = found_q ? entry_q.tag  : 8'd0;
  assign rsp_o.occupancy    = occ_ext[OccW-1:0];

endmodule

[src/priority_requeue_queue.sv]
// ----------------------------------------------------------------------------
// priority_requeue_queue
// Sorted request queue with insert, cancel by pid and serve with requeue.
// ----------------------------------------------------------------------------
// The block handles one request item at a time and is not ready while it
// works. An insert walks the queue from its tail (an empty queue takes the
// entry directly), a cancel and a serve walk it from its head, and a serve of
// a repeat entry removes it and then reinserts it behind its priority band; a
// rejected request, and a serve or cancel on an empty queue, goes straight to
// its result. The walks pass over the entry memory one entry per cycle through
// its single read and single write port, with one compare unit judging each
// entry. The result item is then held until it is taken, and the next request
// is accepted in the following cycle.
module priority_requeue_queue #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  prq_req_if.sink   req_i,
  prq_rsp_if.source rsp_o
);
  import prq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  prq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  prq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[dv/prq_order_checker.sv]
// ----------------------------------------------------------------------------
// prq_order_checker
// Watches the request and response channels of the sorted request queue,
// keeps its own sorted copy of the queue, and compares every response item
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module prq_order_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  prq_req_if          req_mon,
  prq_rsp_if          rsp_mon,
  output int unsigned mismatch_count,
  output int unsigned outstanding,
  output int unsigned results_checked,
  output int unsigned full_seen,
  output int unsigned none_seen,
  output int unsigned invalid_seen,
  output int unsigned requeues_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    status_e         status;
    entry_t          ent;
    logic [OccW-1:0] occupancy;
  } result_t;

  // Entries in service order: falling priority, arrival order within a band.
  entry_t  queued_entries[$];
  result_t pending_results[$];

  // Puts an entry behind every entry of equal or higher priority.
  function automatic void place_entry(entry_t e);
    int unsigned pos;
    pos = 0;
    while (pos < queued_entries.size() && queued_entries[pos].prio >= e.prio) pos++;
    queued_entries.insert(pos, e);
  endfunction

  function automatic result_t apply_request(logic [1:0] op, entry_t req);
    result_t res;
    int      hit;
    res = '0;
    res.status = STATUS_OK;
    hit = -1;
    case (op)
      REQ_INSERT: begin
        if (req.prio == 8'd0) res.status = STATUS_INVALID;
        else if (queued_entries.size() >= QueueDepth) res.status = STATUS_FULL;
        else place_entry(req);
      end
      REQ_CANCEL: begin
        foreach (queued_entries[i]) begin
          if (hit < 0 && queued_entries[i].pid == req.pid) hit = i;
        end
        if (hit < 0) begin
          res.status = STATUS_NONE;
        end else begin
          res.ent = queued_entries[hit];
          queued_entries.delete(hit);
        end
      end
      REQ_SERVE: begin
        if (queued_entries.size() == 0) begin
          res.status = STATUS_NONE;
        end else begin
          res.ent = queued_entries.pop_front();
          if (res.ent.rep) begin
            place_entry(res.ent);
            requeues_seen++;
          end
        end
      end
      default: res.status = STATUS_INVALID;
    endcase
    res.occupancy = OccW'(queued_entries.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_res;
    entry_t  req_ent;
    if (!rst_ni) begin
      queued_entries.delete();
      pending_results.delete();
      mismatch_count  = 0;
      outstanding     = 0;
      results_checked = 0;
      full_seen       = 0;
      none_seen       = 0;
      invalid_seen    = 0;
      requeues_seen   = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        req_ent = '{pid: req_mon.req_pid, prio: req_mon.req_priority,
                    rep: req_mon.req_repeat, tag: req_mon.req_tag};
        pending_results.push_back(apply_request(req_mon.req_type, req_ent));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: response item with no request waiting: status %0d pid %0h",
                     $realtime, rsp_mon.status, rsp_mon.out_pid);
        end else begin
          exp_res = pending_results.pop_front();
          results_checked++;
          case (exp_res.status)
            STATUS_FULL:    full_seen++;
            STATUS_NONE:    none_seen++;
            STATUS_INVALID: invalid_seen++;
            default: ;
          endcase
          if (rsp_mon.status !== exp_res.status ||
              rsp_mon.out_pid !== exp_res.ent.pid ||
              rsp_mon.out_priority !== exp_res.ent.prio ||
              rsp_mon.out_repeat !== exp_res.ent.rep ||
              rsp_mon.out_tag !== exp_res.ent.tag ||
              rsp_mon.occupancy !== exp_res.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $display("%0t: result %0d mismatch", $realtime, results_checked);
              $display("  expected status %0d pid %0h prio %0h rep %0b tag %0h occ %0d",
                       exp_res.status, exp_res.ent.pid, exp_res.ent.prio,
                       exp_res.ent.rep, exp_res.ent.tag, exp_res.occupancy);
              $display("  actual   status %0d pid %0h prio %0h rep %0b tag %0h occ %0d",
                       rsp_mon.status, rsp_mon.out_pid, rsp_mon.out_priority,
                       rsp_mon.out_repeat, rsp_mon.out_tag, rsp_mon.occupancy);
            end
          end
        end
      end
      outstanding = pending_results.size();
    end
  end

endmodule

[dv/priority_requeue_queue_tb.sv]
// ----------------------------------------------------------------------------
// priority_requeue_queue_tb
// Drives request items into the sorted request queue with random gaps on
// both channels and lets prq_order_checker predict and compare every result.
// A directed opening covers the corner cases, then random phases fill,
// drain and churn the queue, with two long response stalls and sender pauses.
// ----------------------------------------------------------------------------
module priority_requeue_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  // The request type code that the block does not define.
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned NumPhases   = 9;
  localparam int unsigned PhaseItems  = 110;
  localparam int unsigned FillItems   = 33;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pid;
    logic [7:0] prio;
    logic       rep;
    logic [7:0] tag;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned items_sent = 0;
  int unsigned results_taken = 0;
  int unsigned idle_cycles = 0;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned full_seen;
  int unsigned none_seen;
  int unsigned invalid_seen;
  int unsigned requeues_seen;

  always #2ns clk_i = ~clk_i;

  prq_req_if req_ch ();
  prq_rsp_if rsp_ch ();

  priority_requeue_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  prq_order_checker order_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon         (req_ch),
    .rsp_mon         (rsp_ch),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .full_seen       (full_seen),
    .none_seen       (none_seen),
    .invalid_seen    (invalid_seen),
    .requeues_seen   (requeues_seen)
  );

  task automatic send_request(request_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.op;
    req_ch.req_pid      <= r.pid;
    req_ch.req_priority <= r.prio;
    req_ch.req_repeat   <= r.rep;
    req_ch.req_tag      <= r.tag;
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Pids come mostly from a small pool so that cancels hit and duplicates
  // occur; priorities mostly from a few bands so that round robin shows.
  function automatic request_t draw_request(int unsigned ins_pct, int unsigned can_pct,
                                            int unsigned srv_pct);
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) r.op = REQ_INSERT;
    else if (pick < ins_pct + can_pct) r.op = REQ_CANCEL;
    else if (pick < ins_pct + can_pct + srv_pct) r.op = REQ_SERVE;
    else r.op = REQ_RESERVED;
    r.pid = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 4) r.prio = 8'd0;
    else if (pick < 60) r.prio = 8'($urandom_range(1, 4));
    else r.prio = 8'($urandom_range(1, 255));
    r.rep = 1'($urandom_range(0, 1));
    r.tag = 8'($urandom_range(0, 255));
    return r;
  endfunction

  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      // Two long stalls let the block sit on a result while the next request waits.
      if (results_taken == 200 || results_taken == 650) gap = LongHold;
      if (gap > 0) begin
        @(negedge clk_i);
        rsp_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready));
      results_taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("Watchdog: no item moved for %0d cycles", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    request_t r;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_INSERT;
    req_ch.req_pid      <= 8'h00;
    req_ch.req_priority <= 8'h00;
    req_ch.req_repeat   <= 1'b0;
    req_ch.req_tag      <= 8'h00;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Serve and cancel on an empty queue, a zero priority, the undefined type.
    send_request(request_t'{REQ_SERVE, 8'h00, 8'h00, 1'b0, 8'h00});
    send_request(request_t'{REQ_CANCEL, 8'hFF, 8'hFF, 1'b1, 8'hFF});
    send_request(request_t'{REQ_INSERT, 8'h12, 8'h00, 1'b1, 8'h34});
    send_request(request_t'{REQ_RESERVED, 8'hFF, 8'hFF, 1'b1, 8'hFF});
    // Field extremes, and two entries sharing the top priority.
    send_request(request_t'{REQ_INSERT, 8'hFF, 8'hFF, 1'b1, 8'hFF});
    send_request(request_t'{REQ_INSERT, 8'h00, 8'h01, 1'b0, 8'h00});
    send_request(request_t'{REQ_INSERT, 8'h55, 8'hFF, 1'b0, 8'hAA});
    send_request(request_t'{REQ_INSERT, 8'hAA, 8'h80, 1'b1, 8'h55});
    // The repeat head goes back behind its band, then the plain one leaves.
    send_request(request_t'{REQ_SERVE, 8'hFF, 8'hFF, 1'b1, 8'hFF});
    send_request(request_t'{REQ_SERVE, 8'h00, 8'h00, 1'b0, 8'h00});
    send_request(request_t'{REQ_CANCEL, 8'hAA, 8'h00, 1'b0, 8'h00});
    send_request(request_t'{REQ_CANCEL, 8'h77, 8'h00, 1'b0, 8'h00});
    send_request(request_t'{REQ_CANCEL, 8'h00, 8'hFF, 1'b1, 8'hFF});
    // A lone repeat entry is served and stays.
    send_request(request_t'{REQ_SERVE, 8'hAB, 8'hCD, 1'b0, 8'hEF});
    send_request(request_t'{REQ_CANCEL, 8'hFF, 8'h00, 1'b0, 8'h00});
    wait_for_results();

    // Fill past capacity, then a zero priority on the full queue.
    for (int unsigned k = 0; k < FillItems; k++) begin
      r = draw_request(100, 0, 0);
      if (r.prio == 8'd0) r.prio = 8'd1;
      send_request(r);
    end
    r = draw_request(100, 0, 0);
    r.prio = 8'd0;
    send_request(r);

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      no_idle = (phase == 4 || phase == 7);
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        case (phase % 3)
          0:       send_request(draw_request(70, 10, 18));
          1:       send_request(draw_request(15, 25, 58));
          default: send_request(draw_request(40, 27, 31));
        endcase
      end
      if (phase % 3 == 2) wait_for_results();
    end
    no_idle = 1'b0;

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results, %0d of them requeued serves.",
             items_sent, results_checked, requeues_seen);
    $display("Rejections: %0d full queue, %0d empty or no match, %0d invalid.",
             full_seen, none_seen, invalid_seen);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
